>>> sv/spci_pkg.sv
// ----------------------------------------------------------------------------
// spci_pkg
// Shared types and constants for the setpoint command input block: beat
// layouts, configuration and state records, register indexes, character codes.
// ----------------------------------------------------------------------------
package spci_pkg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        up_level;
        logic        down_level;
        logic        char_valid;
        logic [7:0]  char_code;
    } in_beat_t;

    typedef struct packed {
        logic [13:0] setpoint_out;
        logic [9:0]  hysteresis_out;
        logic        display_out;
        logic        status_request;
        logic        help_request;
        logic        entry_rejected;
    } out_beat_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } cfg_beat_t;

    typedef enum logic [2:0] {
        REG_SETPOINT_STEP   = 3'd0,
        REG_SETPOINT_MIN    = 3'd1,
        REG_SETPOINT_MAX    = 3'd2,
        REG_HYSTERESIS_STEP = 3'd3,
        REG_HYSTERESIS_MIN  = 3'd4,
        REG_HYSTERESIS_MAX  = 3'd5,
        REG_DEBOUNCE_MS     = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [9:0]  setpoint_step;
        logic [13:0] setpoint_min;
        logic [13:0] setpoint_max;
        logic [9:0]  hysteresis_step;
        logic [9:0]  hysteresis_min;
        logic [9:0]  hysteresis_max;
        logic [15:0] debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic        up_last;
        logic        down_last;
        logic [31:0] up_press_time;
        logic [31:0] down_press_time;
        logic [3:0]  entry_count;
        logic [13:0] entry_value;
        logic        seen_point;
        logic [1:0]  fraction_digits;
        logic        parse_stopped;
        logic [13:0] held_setpoint;
        logic [9:0]  held_hysteresis;
        logic        display_enabled;
    } state_t;

    localparam cfg_t CFG_RESET = '{
        setpoint_step:   10'd50,
        setpoint_min:    14'd1500,
        setpoint_max:    14'd3500,
        hysteresis_step: 10'd25,
        hysteresis_min:  10'd25,
        hysteresis_max:  10'd500,
        debounce_ms:     16'd50
    };

    localparam state_t STATE_RESET = '{
        up_last:         1'b1,
        down_last:       1'b1,
        up_press_time:   32'd0,
        down_press_time: 32'd0,
        entry_count:     4'd0,
        entry_value:     14'd0,
        seen_point:      1'b0,
        fraction_digits: 2'd0,
        parse_stopped:   1'b0,
        held_setpoint:   14'd2500,
        held_hysteresis: 10'd100,
        display_enabled: 1'b1
    };

    localparam logic [13:0] ENTRY_SAT = 14'd16383;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_H_UC  = 8'h48;
    localparam logic [7:0] CH_H_LC  = 8'h68;
    localparam logic [7:0] CH_L_UC  = 8'h4C;
    localparam logic [7:0] CH_L_LC  = 8'h6C;
    localparam logic [7:0] CH_D_UC  = 8'h44;
    localparam logic [7:0] CH_D_LC  = 8'h64;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

>>> sv/spci_stream_if.sv
// ----------------------------------------------------------------------------
// spci_stream_if
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
interface spci_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> sv/spci_tick.sv
// ----------------------------------------------------------------------------
// spci_tick
// Next-state and result logic for one poll tick: button edges with debounce,
// single-character commands and the decimal setpoint entry.
// ----------------------------------------------------------------------------
module spci_tick #(
    parameter int ENTRY_LENGTH = 9
) (
    input  spci_pkg::state_t    state,
    input  spci_pkg::cfg_t      cfg,
    input  spci_pkg::in_beat_t  item,
    output spci_pkg::state_t    state_next,
    output spci_pkg::out_beat_t result
);

    function automatic logic [13:0] sp_up(input logic [13:0] held, input logic [9:0] step,
                                          input logic [13:0] maxv);
        logic [14:0] sum;
        begin
            sum = {1'b0, held} + {5'b0, step};
            return (sum > {1'b0, maxv}) ? maxv : sum[13:0];
        end
    endfunction

    function automatic logic [13:0] sp_down(input logic [13:0] held, input logic [9:0] step,
                                            input logic [13:0] minv);
        logic [14:0] floor_v;
        begin
            floor_v = {1'b0, minv} + {5'b0, step};
            return ({1'b0, held} < floor_v) ? minv : (held - {4'b0, step});
        end
    endfunction

    function automatic logic [9:0] hy_up(input logic [9:0] held, input logic [9:0] step,
                                         input logic [9:0] maxv);
        logic [10:0] sum;
        begin
            sum = {1'b0, held} + {1'b0, step};
            return (sum > {1'b0, maxv}) ? maxv : sum[9:0];
        end
    endfunction

    function automatic logic [9:0] hy_down(input logic [9:0] held, input logic [9:0] step,
                                           input logic [9:0] minv);
        logic [10:0] floor_v;
        begin
            floor_v = {1'b0, minv} + {1'b0, step};
            return ({1'b0, held} < floor_v) ? minv : (held - step);
        end
    endfunction

    function automatic spci_pkg::state_t clear_entry(input spci_pkg::state_t s);
        spci_pkg::state_t r;
        begin
            r                 = s;
            r.entry_count     = 4'd0;
            r.entry_value     = 14'd0;
            r.seen_point      = 1'b0;
            r.fraction_digits = 2'd0;
            r.parse_stopped   = 1'b0;
            return r;
        end
    endfunction

    always_comb
    begin
        spci_pkg::state_t s;
        logic [31:0]      up_age;
        logic [31:0]      down_age;
        logic [3:0]       digit;
        logic [17:0]      sum_v;
        logic             stat;
        logic             help;
        logic             rej;

        s        = state;
        stat     = 1'b0;
        help     = 1'b0;
        rej      = 1'b0;
        up_age   = item.now_ms - state.up_press_time;
        down_age = item.now_ms - state.down_press_time;
        digit    = 4'(item.char_code - spci_pkg::CH_ZERO);
        sum_v    = 18'd0;

        if (!item.up_level && s.up_last && (up_age >= {16'd0, cfg.debounce_ms}))
        begin
            s.up_press_time = item.now_ms;
            s.held_setpoint = sp_up(s.held_setpoint, cfg.setpoint_step, cfg.setpoint_max);
        end
        s.up_last = item.up_level;

        if (!item.down_level && s.down_last && (down_age >= {16'd0, cfg.debounce_ms}))
        begin
            s.down_press_time = item.now_ms;
            s.held_setpoint   = sp_down(s.held_setpoint, cfg.setpoint_step, cfg.setpoint_min);
        end
        s.down_last = item.down_level;

        if (item.char_valid)
        begin
            case (item.char_code) inside
                spci_pkg::CH_PLUS:
                begin
                    s = clear_entry(s);
                    s.held_setpoint = sp_up(s.held_setpoint, cfg.setpoint_step,
                                            cfg.setpoint_max);
                end
                spci_pkg::CH_MINUS:
                begin
                    s = clear_entry(s);
                    s.held_setpoint = sp_down(s.held_setpoint, cfg.setpoint_step,
                                              cfg.setpoint_min);
                end
                spci_pkg::CH_H_UC, spci_pkg::CH_H_LC:
                begin
                    s = clear_entry(s);
                    s.held_hysteresis = hy_up(s.held_hysteresis, cfg.hysteresis_step,
                                              cfg.hysteresis_max);
                end
                spci_pkg::CH_L_UC, spci_pkg::CH_L_LC:
                begin
                    s = clear_entry(s);
                    s.held_hysteresis = hy_down(s.held_hysteresis, cfg.hysteresis_step,
                                                cfg.hysteresis_min);
                end
                spci_pkg::CH_D_UC, spci_pkg::CH_D_LC:
                begin
                    s = clear_entry(s);
                    s.display_enabled = ~s.display_enabled;
                end
                spci_pkg::CH_QUERY:
                begin
                    s    = clear_entry(s);
                    stat = 1'b1;
                end
                spci_pkg::CH_SLASH:
                begin
                    s    = clear_entry(s);
                    help = 1'b1;
                end
                spci_pkg::CH_CR, spci_pkg::CH_LF:
                begin
                    if (s.entry_count != 4'd0)
                    begin
                        if ((s.entry_value >= cfg.setpoint_min) &&
                            (s.entry_value <= cfg.setpoint_max))
                        begin
                            s.held_setpoint = s.entry_value;
                        end
                        else
                        begin
                            rej = 1'b1;
                        end
                        s = clear_entry(s);
                    end
                end
                [spci_pkg::CH_ZERO:spci_pkg::CH_NINE], spci_pkg::CH_POINT:
                begin
                    if (s.entry_count < 4'(ENTRY_LENGTH))
                    begin
                        s.entry_count = s.entry_count + 4'd1;
                        if (!s.parse_stopped)
                        begin
                            if (item.char_code == spci_pkg::CH_POINT)
                            begin
                                if (s.seen_point)
                                    s.parse_stopped = 1'b1;
                                else
                                    s.seen_point = 1'b1;
                            end
                            else
                            begin
                                if (!s.seen_point)
                                begin
                                    sum_v = 18'(s.entry_value) * 18'd10
                                          + 18'(digit) * 18'd100;
                                end
                                else if (s.fraction_digits == 2'd0)
                                begin
                                    sum_v = 18'(s.entry_value) + 18'(digit) * 18'd10;
                                    s.fraction_digits = 2'd1;
                                end
                                else if (s.fraction_digits == 2'd1)
                                begin
                                    sum_v = 18'(s.entry_value) + 18'(digit);
                                    s.fraction_digits = 2'd2;
                                end
                                else
                                begin
                                    sum_v = 18'(s.entry_value);
                                end
                                s.entry_value = (sum_v > 18'(spci_pkg::ENTRY_SAT)) ?
                                                spci_pkg::ENTRY_SAT : sum_v[13:0];
                            end
                        end
                    end
                end
                default:
                begin
                    s = clear_entry(s);
                end
            endcase
        end

        state_next            = s;
        result.setpoint_out   = s.held_setpoint;
        result.hysteresis_out = s.held_hysteresis;
        result.display_out    = s.display_enabled;
        result.status_request = stat;
        result.help_request   = help;
        result.entry_rejected = rej;
    end

endmodule

>>> sv/setpoint_command_input_core.sv
// ----------------------------------------------------------------------------
// setpoint_command_input_core
// Setpoint and hysteresis control from two push buttons and a serial command
// stream, with debounce, clamped steps and a typed decimal setpoint entry.
//
//   port    dir   payload      beat meaning
//   cmd     sink  in_beat_t    one poll tick: time, button levels, character
//   result  src   out_beat_t   settings and request pulses after that tick
//   cfg     sink  cfg_beat_t   register write, index and data
//
// A tick beat lands in the input register, is processed by the tick logic and
// shows up in the result register, one beat per cycle while result is not stalled.
// The held setpoint and entry state update in the cycle the result is loaded.
// A stalled result holds the pipe; the input register still takes a beat when
// the result register drains in the same cycle. cfg is always ready.
// Reset restores the register defaults and the power-on settings.
// ----------------------------------------------------------------------------
module setpoint_command_input_core #(
    parameter int ENTRY_LENGTH = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    spci_stream_if.sink   cmd,
    spci_stream_if.source result,
    spci_stream_if.sink   cfg
);

    logic                in_valid_reg;
    spci_pkg::in_beat_t  in_reg;
    spci_pkg::state_t    state_reg;
    spci_pkg::state_t    state_next;
    spci_pkg::cfg_t      cfg_reg;
    spci_pkg::out_beat_t res_next;
    spci_pkg::out_beat_t res_reg;
    logic                res_valid_reg;
    logic                advance;

    assign advance      = in_valid_reg && (!res_valid_reg || result.ready);
    assign cmd.ready    = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    spci_tick #(
        .ENTRY_LENGTH (ENTRY_LENGTH)
    ) u_tick (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (in_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= spci_pkg::STATE_RESET;
        end
        else
        begin
            if (cmd.ready)
                in_valid_reg <= cmd.valid;
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            in_reg <= cmd.data;
        if (advance)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= spci_pkg::CFG_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                spci_pkg::REG_SETPOINT_STEP:   cfg_reg.setpoint_step   <= cfg.data.data[9:0];
                spci_pkg::REG_SETPOINT_MIN:    cfg_reg.setpoint_min    <= cfg.data.data[13:0];
                spci_pkg::REG_SETPOINT_MAX:    cfg_reg.setpoint_max    <= cfg.data.data[13:0];
                spci_pkg::REG_HYSTERESIS_STEP: cfg_reg.hysteresis_step <= cfg.data.data[9:0];
                spci_pkg::REG_HYSTERESIS_MIN:  cfg_reg.hysteresis_min  <= cfg.data.data[9:0];
                spci_pkg::REG_HYSTERESIS_MAX:  cfg_reg.hysteresis_max  <= cfg.data.data[9:0];
                spci_pkg::REG_DEBOUNCE_MS:     cfg_reg.debounce_ms     <= cfg.data.data;
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

endmodule
